// ----- rtl/vst_pkg.sv -----
`timescale 1ns / 1ps
package vst_pkg;

  localparam int unsigned TagW   = 64;
  localparam int unsigned TimeW  = 48;
  localparam int unsigned DelayW = 32;
  localparam int unsigned CountW = 6;
  localparam int unsigned AddrW  = 3;
  localparam int unsigned DataW  = 32;

  localparam logic [31:0] DelayReset = 32'd15000;

  localparam logic       ReqQuery = 1'b0;
  localparam logic       ReqFlag  = 1'b1;

  localparam logic       RegDelay = 1'b0;

  typedef struct packed {
    logic load_req;
    logic compare;
    logic update;
    logic load_out;
  } cmd_t;

  typedef struct packed {
    logic out_free;
  } status_t;

endpackage

// ----- rtl/vst_ctrl.sv -----
`timescale 1ns / 1ps
module vst_ctrl
  import vst_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  output logic    in_stall_o,
  input  status_t status_i,
  output cmd_t    cmd_o
);

  localparam logic [1:0] StIdle    = 2'd0;
  localparam logic [1:0] StCompare = 2'd1;
  localparam logic [1:0] StUpdate  = 2'd2;
  localparam logic [1:0] StCount   = 2'd3;

  logic [1:0] state_q, state_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      StIdle: begin
        if (in_valid_i) begin
          cmd_o.load_req = 1'b1;
          state_d        = StCompare;
        end
      end
      StCompare: begin
        cmd_o.compare = 1'b1;
        state_d       = StUpdate;
      end
      StUpdate: begin
        cmd_o.update = 1'b1;
        state_d      = StCount;
      end
      StCount: begin
        if (status_i.out_free) begin
          cmd_o.load_out = 1'b1;
          state_d        = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  assign in_stall_o = (state_q != StIdle);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// ----- rtl/vst_dp.sv -----
`timescale 1ns / 1ps
module vst_dp
  import vst_pkg::*;
#(
  parameter int unsigned ENTRIES = 32
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  cmd_t              cmd_i,
  output status_t           status_o,
  input  logic              cfg_we_i,
  input  logic [DelayW-1:0] cfg_wdata_i,
  output logic [DelayW-1:0] expiry_delay_o,
  input  logic              req_type_i,
  input  logic [TagW-1:0]   root_tag_i,
  input  logic [TagW-1:0]   hash_tag_i,
  input  logic [TimeW-1:0]  now_time_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic              votable_o,
  output logic              dropped_o,
  output logic [CountW-1:0] entry_count_o
);

  localparam int unsigned CntW = $clog2(ENTRIES + 1);

  logic [DelayW-1:0] delay_q;

  // request registers
  logic             type_q;
  logic [TagW-1:0]  root_q, hash_q;
  logic [TimeW-1:0] now_q, lim_q;
  logic             has_lim_q;

  // slot table
  logic [ENTRIES-1:0] valid_q, valid_d;
  logic [TagW-1:0]    slot_root_q [ENTRIES];
  logic [TagW-1:0]    slot_hash_q [ENTRIES];
  logic [TimeW-1:0]   slot_time_q [ENTRIES];

  // compare results
  logic [ENTRIES-1:0] match_q, hash_eq_q, lt_q, le_q;
  logic [ENTRIES-1:0] match_d, hash_eq_d, lt_d, le_d;

  logic votable_q, dropped_q;
  logic out_valid_q, votable_out_q, dropped_out_q;
  logic [CountW-1:0] count_out_q;

  // cutoff: now minus delay
  logic [TimeW-1:0] delay_ext;
  assign delay_ext = {{(TimeW - DelayW){1'b0}}, delay_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      delay_q <= DelayReset;
    end else if (cfg_we_i) begin
      delay_q <= cfg_wdata_i;
    end
  end

  assign expiry_delay_o = delay_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_req) begin
      type_q    <= req_type_i;
      root_q    <= root_tag_i;
      hash_q    <= hash_tag_i;
      now_q     <= now_time_i;
      lim_q     <= now_time_i - delay_ext;
      has_lim_q <= (now_time_i >= delay_ext);
    end
  end

  // per-slot compares
  always_comb begin
    for (int i = 0; i < ENTRIES; i++) begin
      match_d[i]   = valid_q[i] && (slot_root_q[i] == root_q);
      hash_eq_d[i] = (slot_hash_q[i] == hash_q);
      lt_d[i]      = has_lim_q && (slot_time_q[i] < lim_q);
      le_d[i]      = valid_q[i] && has_lim_q && (slot_time_q[i] <= lim_q);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.compare) begin
      match_q   <= match_d;
      hash_eq_q <= hash_eq_d;
      lt_q      <= lt_d;
      le_q      <= le_d;
    end
  end

  // update of the table
  logic [ENTRIES-1:0] kept, hit, free, ins;
  logic               found, full;

  always_comb begin
    kept    = valid_q & ~le_q;
    hit     = match_q & ~le_q;
    found   = |hit;
    free    = ~kept;
    ins     = free & (~free + {{(ENTRIES - 1){1'b0}}, 1'b1});
    full    = ~|free;
    valid_d = valid_q;
    if (type_q == ReqFlag) begin
      valid_d = found ? kept : (kept | ins);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (cmd_i.update) begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.update) begin
      votable_q <= (type_q == ReqQuery) && (&(~match_q | hash_eq_q | lt_q));
      dropped_q <= (type_q == ReqFlag) && !found && full;
      for (int i = 0; i < ENTRIES; i++) begin
        if (type_q == ReqFlag) begin
          if (hit[i] || (!found && ins[i])) begin
            slot_time_q[i] <= now_q;
          end
          if (!found && ins[i]) begin
            slot_root_q[i] <= root_q;
            slot_hash_q[i] <= hash_q;
          end
        end
      end
    end
  end

  // live count
  logic [CntW-1:0]        cnt;
  logic [CntW+CountW-1:0] cnt_ext;

  always_comb begin
    cnt = '0;
    for (int i = 0; i < ENTRIES; i++) begin
      cnt = cnt + {{(CntW - 1){1'b0}}, valid_q[i]};
    end
    cnt_ext = {{CountW{1'b0}}, cnt};
  end

  // output register
  assign status_o.out_free = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.load_out) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      votable_out_q <= votable_q;
      dropped_out_q <= dropped_q;
      count_out_q   <= cnt_ext[CountW-1:0];
    end
  end

  assign out_valid_o   = out_valid_q;
  assign votable_o     = votable_out_q;
  assign dropped_o     = dropped_out_q;
  assign entry_count_o = count_out_q;

endmodule

// ----- rtl/vote_spacing_table.sv -----
`timescale 1ns / 1ps
// vote spacing table: a root-keyed table of recent votes with a time window
// input channel (in_valid_i / in_stall_o) carries one request: req_type_i
// selects a query (votable?) or a flag (record vote), with root and hash
// tags and the current time. each request gives exactly one result on the
// output channel (out_valid_o / out_stall_i): votable, dropped, entry_count.
// a request walks the steps of the 4-state controller: capture and cutoff,
// parallel compare over all slots, table update, live count. no new request
// is taken until the previous one has left its count step.
// the output register holds a finished result while the receiver stalls;
// a new request is still taken and runs until its count step, which waits
// for the output register to free up.
// expiry_delay sits at APB byte address 0 (reset 15000); write it only
// while no request is in flight.
// reset empties the table (all slots invalid, count zero) with no clearing
// pass; in_stall_o is low right after reset.
module vote_spacing_table
  import vst_pkg::*;
#(
  parameter int unsigned ENTRIES = 32
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [AddrW-1:0]  paddr,
  input  logic [DataW-1:0]  pwdata,
  output logic [DataW-1:0]  prdata,
  output logic              pready,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic              req_type_i,
  input  logic [TagW-1:0]   root_tag_i,
  input  logic [TagW-1:0]   hash_tag_i,
  input  logic [TimeW-1:0]  now_time_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic              votable_o,
  output logic              dropped_o,
  output logic [CountW-1:0] entry_count_o
);

  cmd_t              cmd;
  status_t           status;
  logic              cfg_we;
  logic [DelayW-1:0] delay;

  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite && (paddr[2] == RegDelay);
  assign prdata = (paddr[2] == RegDelay) ? delay : '0;

  vst_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  vst_dp #(
    .ENTRIES (ENTRIES)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .status_o       (status),
    .cfg_we_i       (cfg_we),
    .cfg_wdata_i    (pwdata),
    .expiry_delay_o (delay),
    .req_type_i     (req_type_i),
    .root_tag_i     (root_tag_i),
    .hash_tag_i     (hash_tag_i),
    .now_time_i     (now_time_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .votable_o      (votable_o),
    .dropped_o      (dropped_o),
    .entry_count_o  (entry_count_o)
  );

  a_busy_after_request: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> in_stall_o)
    else $error("request taken while busy");

  a_flags_exclusive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(votable_o && dropped_o))
    else $error("votable and dropped both set");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (ENTRIES < 64)) |-> (entry_count_o <= ENTRIES))
    else $error("entry count above table size");

endmodule

// ----- dv/tb_vote_spacing_table.sv -----
`timescale 1ns / 1ps
module tb_vote_spacing_table;
  import vst_pkg::*;

  localparam int unsigned Slots      = 32;
  localparam int unsigned CycleLimit = 400000;
  localparam int unsigned RootPool   = 40;
  localparam int unsigned HashPool   = 4;
  localparam int unsigned PhaseItems = 322;
  localparam logic [AddrW-1:0] DelayAddr = AddrW'(4 * RegDelay);
  localparam logic [TimeW-1:0] TimeTop   = {TimeW{1'b1}};

  typedef struct packed {
    logic             kind;
    logic [TagW-1:0]  root;
    logic [TagW-1:0]  hash;
    logic [TimeW-1:0] now;
  } req_t;

  typedef struct packed {
    logic              votable;
    logic              dropped;
    logic [CountW-1:0] count;
  } verdict_t;

  typedef struct packed {
    req_t     r;
    bit       typed;
    verdict_t v;
  } row_t;

  logic              clk_i       = 1'b0;
  logic              rst_ni      = 1'b0;
  logic              psel        = 1'b0;
  logic              penable     = 1'b0;
  logic              pwrite      = 1'b0;
  logic [AddrW-1:0]  paddr       = '0;
  logic [DataW-1:0]  pwdata      = '0;
  logic [DataW-1:0]  prdata;
  logic              pready;
  logic              in_valid_i  = 1'b0;
  logic              in_stall_o;
  logic              req_type_i  = ReqQuery;
  logic [TagW-1:0]   root_tag_i  = '0;
  logic [TagW-1:0]   hash_tag_i  = '0;
  logic [TimeW-1:0]  now_time_i  = '0;
  logic              out_valid_o;
  logic              out_stall_i = 1'b0;
  logic              votable_o;
  logic              dropped_o;
  logic [CountW-1:0] entry_count_o;

  // predictor state
  logic [DelayW-1:0] window_ticks = DelayReset;
  bit                tbl_live [Slots];
  logic [TagW-1:0]   tbl_root [Slots];
  logic [TagW-1:0]   tbl_hash [Slots];
  logic [TimeW-1:0]  tbl_time [Slots];
  logic [CountW-1:0] tbl_count = '0;

  verdict_t verdict_q [$];
  row_t     directed_rows [$];
  verdict_t want_v;
  int unsigned mismatch_cnt = 0;
  int unsigned results_seen = 0;
  int unsigned cycle_cnt    = 0;

  vote_spacing_table dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .req_type_i    (req_type_i),
    .root_tag_i    (root_tag_i),
    .hash_tag_i    (hash_tag_i),
    .now_time_i    (now_time_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .votable_o     (votable_o),
    .dropped_o     (dropped_o),
    .entry_count_o (entry_count_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt >= CycleLimit) begin
      $display("vote_spacing_table regression: fail");
      $finish;
    end
  end

  function automatic void note_mismatch(input string what, input logic [63:0] want,
                                        input logic [63:0] got);
    mismatch_cnt++;
    if (mismatch_cnt <= 10)
      $display("mismatch %0s: expected %h, got %h", what, want, got);
  endfunction

  function automatic verdict_t apply_request(input req_t r);
    verdict_t v;
    bit has_lim;
    bit ok;
    bit found;
    logic [TimeW-1:0] lim;
    v = '0;
    has_lim = r.now >= TimeW'(window_ticks);
    lim = r.now - TimeW'(window_ticks);
    if (r.kind == ReqQuery) begin
      ok = 1'b1;
      for (int i = 0; i < Slots; i++) begin
        if (tbl_live[i] && tbl_root[i] == r.root &&
            !(tbl_hash[i] == r.hash || (has_lim && tbl_time[i] < lim)))
          ok = 1'b0;
      end
      v.votable = ok;
    end else begin
      found = 1'b0;
      if (has_lim) begin
        for (int i = 0; i < Slots; i++) begin
          if (tbl_live[i] && tbl_time[i] <= lim) begin
            tbl_live[i] = 1'b0;
            tbl_count--;
          end
        end
      end
      for (int i = 0; i < Slots; i++) begin
        if (!found && tbl_live[i] && tbl_root[i] == r.root) begin
          tbl_time[i] = r.now;
          found = 1'b1;
        end
      end
      // new roots take the lowest free slot
      for (int i = 0; i < Slots; i++) begin
        if (!found && !tbl_live[i]) begin
          tbl_live[i] = 1'b1;
          tbl_root[i] = r.root;
          tbl_hash[i] = r.hash;
          tbl_time[i] = r.now;
          tbl_count++;
          found = 1'b1;
        end
      end
      v.dropped = !found;
    end
    v.count = tbl_count;
    return v;
  endfunction

  // called at a falling edge, returns at the falling edge after acceptance
  task automatic send_req(input req_t r, input bit typed, input verdict_t fixed);
    verdict_t v;
    in_valid_i <= 1'b1;
    req_type_i <= r.kind;
    root_tag_i <= r.root;
    hash_tag_i <= r.hash;
    now_time_i <= r.now;
    do @(posedge clk_i); while (in_stall_o);
    v = apply_request(r);
    if (typed) v = fixed;
    verdict_q.insert(verdict_q.size(), v);
    @(negedge clk_i);
  endtask

  task automatic wait_all_verdicts();
    while (verdict_q.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic set_delay(input logic [DelayW-1:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= DelayAddr;
    pwdata  <= val;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    window_ticks = val;
    @(negedge clk_i);
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    if (prdata[DelayW-1:0] !== val)
      note_mismatch("expiry_delay readback", 64'(val), 64'(prdata));
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic add_row(input logic kind, input logic [TagW-1:0] root,
                         input logic [TagW-1:0] hash, input logic [TimeW-1:0] now,
                         input bit typed, input logic vot, input logic drp,
                         input logic [CountW-1:0] cnt);
    row_t w;
    w.r     = '{kind: kind, root: root, hash: hash, now: now};
    w.typed = typed;
    w.v     = '{votable: vot, dropped: drp, count: cnt};
    directed_rows.insert(directed_rows.size(), w);
  endtask

  task automatic run_phase(input logic [DelayW-1:0] delay, input logic [TimeW-1:0] base,
                           input int n, input int jump_pct, input bit pause_mid);
    logic [TagW-1:0]  roots  [RootPool];
    logic [TagW-1:0]  hashes [HashPool];
    logic [TimeW-1:0] t;
    logic [31:0]      span;
    req_t r;
    int i;
    int burst;
    int gap;
    int pick;
    wait_all_verdicts();
    set_delay(delay);
    for (int k = 0; k < RootPool; k++) roots[k] = {$urandom, $urandom};
    for (int k = 0; k < HashPool; k++) hashes[k] = {$urandom, $urandom};
    span = (delay >> 7) + 3;
    t = base;
    i = 0;
    while (i < n) begin
      burst = $urandom_range(1, 24);
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
      while (burst > 0 && i < n) begin
        pick = $urandom_range(0, 99);
        if (pick < 3) t = t - TimeW'($urandom_range(0, 2000));
        else if (pick < 3 + jump_pct)
          t = t + TimeW'(delay) + TimeW'($urandom_range(0, span));
        else if (pick < 3 + 2 * jump_pct) t = t + TimeW'($urandom_range(0, delay));
        else if (pick >= 15 + 2 * jump_pct) t = t + TimeW'($urandom_range(0, span));
        r.kind = $urandom_range(0, 1) ? ReqFlag : ReqQuery;
        if ($urandom_range(0, 9) == 0) begin
          r.root = {$urandom, $urandom};
          r.hash = {$urandom, $urandom};
        end else begin
          r.root = roots[$urandom_range(0, RootPool - 1)];
          r.hash = hashes[$urandom_range(0, HashPool - 1)];
        end
        r.now = t;
        send_req(r, 1'b0, '0);
        i++;
        burst--;
        if (pause_mid && i == n / 2) begin
          in_valid_i <= 1'b0;
          wait_all_verdicts();
        end
      end
      if (gap > 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end
    end
    in_valid_i <= 1'b0;
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      results_seen++;
      if (verdict_q.size() == 0) begin
        note_mismatch("result with no request waiting", '0,
                      64'({votable_o, dropped_o, entry_count_o}));
      end else begin
        want_v = verdict_q[0];
        verdict_q.delete(0);
        if (votable_o !== want_v.votable)
          note_mismatch("votable", 64'(want_v.votable), 64'(votable_o));
        if (dropped_o !== want_v.dropped)
          note_mismatch("dropped", 64'(want_v.dropped), 64'(dropped_o));
        if (entry_count_o !== want_v.count)
          note_mismatch("entry_count", 64'(want_v.count), 64'(entry_count_o));
      end
    end
  end

  // receiver: changing stall patterns plus one long hold-off
  initial begin
    int mode;
    int mode_left;
    int hold_left;
    bit held;
    mode = 0;
    mode_left = 0;
    hold_left = 0;
    held = 1'b0;
    forever begin
      @(negedge clk_i);
      if (!held && results_seen >= 600) begin
        held = 1'b1;
        hold_left = 150;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall_i <= 1'b1;
      end else begin
        if (mode_left == 0) begin
          mode = $urandom_range(0, 3);
          mode_left = $urandom_range(20, 150);
        end
        mode_left--;
        case (mode)
          0: out_stall_i <= 1'b0;
          1: out_stall_i <= ($urandom_range(0, 9) < 3);
          2: out_stall_i <= ($urandom_range(0, 9) < 7);
          default: out_stall_i <= (mode_left % 4 == 0);
        endcase
      end
    end
  end

  initial begin
    logic [TagW-1:0] root_a;
    logic [TagW-1:0] root_b;
    logic [TagW-1:0] hash_1;
    logic [TagW-1:0] hash_2;
    logic [TagW-1:0] ones;
    logic [TagW-1:0] alt_a;
    logic [TagW-1:0] alt_5;
    root_a = 64'h0123_4567_89ab_cdef;
    root_b = 64'hfedc_ba98_7654_3210;
    hash_1 = 64'h1111_1111_1111_1111;
    hash_2 = 64'h2222_2222_2222_2222;
    ones   = {TagW{1'b1}};
    alt_a  = 64'haaaa_aaaa_aaaa_aaaa;
    alt_5  = 64'h5555_5555_5555_5555;

    // empty table, early time, hash match and mismatch, refresh keeps hash
    add_row(ReqQuery, root_a, hash_1, 48'd0,     1, 1'b1, 1'b0, 6'd0);
    add_row(ReqFlag,  root_a, hash_1, 48'd0,     1, 1'b0, 1'b0, 6'd1);
    add_row(ReqQuery, root_a, hash_2, 48'd100,   1, 1'b0, 1'b0, 6'd1);
    add_row(ReqQuery, root_a, hash_1, 48'd100,   1, 1'b1, 1'b0, 6'd1);
    add_row(ReqFlag,  root_a, hash_2, 48'd200,   1, 1'b0, 1'b0, 6'd1);
    add_row(ReqQuery, root_a, hash_2, 48'd300,   1, 1'b0, 1'b0, 6'd1);
    add_row(ReqFlag,  ones,   '0,     48'd15000, 1, 1'b0, 1'b0, 6'd2);
    // entry time equal to cutoff still blocks, one tick later it is old
    add_row(ReqQuery, root_a, hash_2, 48'd15200, 1, 1'b0, 1'b0, 6'd2);
    add_row(ReqQuery, root_a, hash_2, 48'd15201, 1, 1'b1, 1'b0, 6'd2);
    add_row(ReqFlag,  '0,     ones,   48'd15200, 1, 1'b0, 1'b0, 6'd2);
    add_row(ReqQuery, ones,   alt_a,  48'd15200, 1, 1'b0, 1'b0, 6'd2);
    // time going backwards
    add_row(ReqQuery, '0,     64'd5,  48'd10,    1, 1'b0, 1'b0, 6'd2);
    add_row(ReqFlag,  '0,     64'd7,  48'd10,    1, 1'b0, 1'b0, 6'd2);
    // top of the time range expires everything
    add_row(ReqFlag,  root_b, hash_1, TimeTop,   1, 1'b0, 1'b0, 6'd1);
    add_row(ReqQuery, root_b, hash_2, TimeTop,   1, 1'b0, 1'b0, 6'd1);
    add_row(ReqQuery, '0,     hash_2, TimeTop,   1, 1'b1, 1'b0, 6'd1);
    add_row(ReqFlag,  alt_a,  alt_5,  TimeTop,   0, 1'b0, 1'b0, '0);
    add_row(ReqQuery, alt_a,  alt_a,  TimeTop,   0, 1'b0, 1'b0, '0);
    add_row(ReqQuery, alt_5,  alt_5,  TimeTop,   0, 1'b0, 1'b0, '0);
    add_row(ReqFlag,  alt_5,  alt_a,  TimeTop,   0, 1'b0, 1'b0, '0);
    add_row(ReqQuery, root_b, hash_1, TimeTop,   0, 1'b0, 1'b0, '0);

    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    foreach (directed_rows[k]) begin
      send_req(directed_rows[k].r, directed_rows[k].typed, directed_rows[k].v);
      if ($urandom_range(0, 2) == 0) begin
        in_valid_i <= 1'b0;
        repeat ($urandom_range(1, 3)) @(negedge clk_i);
      end
    end
    in_valid_i <= 1'b0;

    run_phase(32'hffff_ffff, '0, PhaseItems, 0, 1'b1);
    run_phase(32'd0, TimeW'({$urandom, $urandom}), PhaseItems, 0, 1'b0);
    run_phase(DelayReset, TimeW'({$urandom, $urandom}), PhaseItems, 5, 1'b0);
    run_phase(32'd1, TimeTop - 48'hfff, PhaseItems, 0, 1'b0);
    run_phase($urandom, TimeW'({$urandom, $urandom}), PhaseItems, 3, 1'b0);
    run_phase($urandom_range(16, 300), TimeW'({$urandom, $urandom}), PhaseItems, 8, 1'b0);

    wait_all_verdicts();
    repeat (12) @(posedge clk_i);
    if (mismatch_cnt == 0 && verdict_q.size() == 0) begin
      $display("vote_spacing_table regression: pass");
    end else begin
      $display("vote_spacing_table regression: fail");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
rtl/vst_pkg.sv
rtl/vst_ctrl.sv
rtl/vst_dp.sv
rtl/vote_spacing_table.sv
dv/tb_vote_spacing_table.sv
